// ----- hdl/tpgfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tpgfc_pkg;

  // Largest effective frame dimension
  localparam int unsigned MAX_DIMENSION = 4096;
  localparam int unsigned DIM_W = 13;

  // Divider: 20-bit dividend, one quotient bit per cycle
  localparam int unsigned NUM_W     = 20;
  localparam int unsigned DIV_STEPS = NUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  // Four bytes per pixel into the CRC
  localparam int unsigned PIX_BYTES = 4;
  localparam int unsigned BYTE_IDX_W = 2;

  localparam logic [31:0] CRC_POLY = 32'h82F6_3B78;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Pattern codes
  localparam logic [1:0] PAT_PASS  = 2'd0;
  localparam logic [1:0] PAT_BARS  = 2'd1;
  localparam logic [1:0] PAT_CHECK = 2'd2;
  localparam logic [1:0] PAT_GRAD  = 2'd3;

  // Register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_PATTERN    = 2'd0;
  localparam logic [1:0] REG_ACT_WIDTH  = 2'd1;
  localparam logic [1:0] REG_ACT_HEIGHT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_DIV_B,
    ST_PIX,
    ST_CRC,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]       pattern;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_b;
    logic pix;
    logic crc_step;
    logic commit;
  } ctrl_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/tpgfc_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgfc_regs
  import tpgfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern <= PAT_PASS;
      cfg_r.width   <= DIM_W'(800);
      cfg_r.height  <= DIM_W'(600);
    end else if (wr_en) begin
      unique case (cfg_paddr[3:2])
        REG_PATTERN:    cfg_r.pattern <= cfg_pwdata[1:0];
        REG_ACT_WIDTH:  cfg_r.width   <= cfg_pwdata[DIM_W-1:0];
        REG_ACT_HEIGHT: cfg_r.height  <= cfg_pwdata[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_PATTERN:    cfg_prdata = {30'd0, cfg_r.pattern};
      REG_ACT_WIDTH:  cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.width};
      REG_ACT_HEIGHT: cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.height};
      default:        cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/tpgfc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgfc_ctrl
  import tpgfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire logic [1:0] pattern,
  output ctrl_cmd_t       cmd
);

  state_t state_r, state_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;
  logic [BYTE_IDX_W-1:0] byte_r, byte_nxt;
  logic out_valid_r, out_valid_nxt;
  logic div_last, crc_last, slot_free;

  assign div_last  = (step_r == STEP_W'(DIV_STEPS - 1));
  assign crc_last  = (byte_r == BYTE_IDX_W'(PIX_BYTES - 1));
  assign slot_free = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) begin
        state_nxt = (pattern == PAT_BARS || pattern == PAT_GRAD) ? ST_DIV_A : ST_PIX;
      end
      ST_DIV_A: if (div_last) begin
        state_nxt = (pattern == PAT_GRAD) ? ST_DIV_B : ST_PIX;
      end
      ST_DIV_B: if (div_last) begin
        state_nxt = ST_PIX;
      end
      ST_PIX:   state_nxt = ST_CRC;
      ST_CRC:   if (crc_last) begin
        state_nxt = ST_DONE;
      end
      ST_DONE:  if (slot_free) begin
        state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_DIV_A: begin
        cmd.div_step = 1'b1;
        cmd.load_b   = div_last && (pattern == PAT_GRAD);
      end
      ST_DIV_B: cmd.div_step = 1'b1;
      ST_PIX:   cmd.pix = 1'b1;
      ST_CRC:   cmd.crc_step = 1'b1;
      ST_DONE:  cmd.commit = slot_free;
      default: ;
    endcase
  end

  // counters and output valid
  always_comb begin
    step_nxt = (state_r == ST_DIV_A || state_r == ST_DIV_B)
               ? (div_last ? '0 : step_r + 1'b1) : '0;
    byte_nxt = (state_r == ST_CRC) ? byte_r + 1'b1 : '0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      byte_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      byte_r      <= byte_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tpgfc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgfc_dp
  import tpgfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire ctrl_cmd_t   cmd,
  input  wire logic [11:0] in_column,
  input  wire logic [11:0] in_row,
  input  wire logic [31:0] in_source_pixel,
  input  wire logic        in_start_of_frame,
  input  wire logic        in_end_of_frame,
  output logic [31:0]      out_pixel,
  output logic             out_frame_done,
  output logic [31:0]      out_frame_signature,
  output logic [31:0]      out_frames_sent,
  output logic [63:0]      out_bytes_sent
);

  // one CRC-32C byte update, reflected
  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] v;
    v = c ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      v = v[0] ? ((v >> 1) ^ CRC_POLY) : (v >> 1);
    end
    return v;
  endfunction

  function automatic logic [7:0] sat8(input logic [NUM_W-1:0] q);
    return (q > NUM_W'(255)) ? 8'hFF : q[7:0];
  endfunction

  // latched item
  logic [11:0] row_r, col_r;
  logic [31:0] src_r;
  logic        eof_r;

  // divider
  logic [NUM_W-1:0] num_r;
  logic [DIM_W-1:0] rem_r, den_r;
  logic [DIM_W:0]   rem_sh;
  logic             qbit;
  logic [NUM_W-1:0] num_nxt;
  logic [DIM_W-1:0] rem_nxt;
  logic [7:0]       red_r;

  // effective dimensions
  logic [DIM_W-1:0] wc, hc, den_w, den_h;

  // pixel, CRC and counters
  logic [31:0] px_r, px_nxt, sh_r, crc_r, sig_r, frames_r;
  logic [63:0] open_r, bytes_r, open_add;
  logic [19:0] col_x255, row_x255;

  assign wc = (cfg.width == '0) ? DIM_W'(1)
            : (cfg.width > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : cfg.width;
  assign hc = (cfg.height == '0) ? DIM_W'(1)
            : (cfg.height > DIM_W'(MAX_DIMENSION)) ? DIM_W'(MAX_DIMENSION) : cfg.height;
  assign den_w = (wc > DIM_W'(1)) ? wc - 1'b1 : DIM_W'(1);
  assign den_h = (hc > DIM_W'(1)) ? hc - 1'b1 : DIM_W'(1);

  assign col_x255 = 20'(in_column) * 20'd255;
  assign row_x255 = 20'(row_r) * 20'd255;

  // restoring divide step
  always_comb begin
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    qbit    = (rem_sh >= {1'b0, den_r});
    rem_nxt = qbit ? DIM_W'(rem_sh - {1'b0, den_r}) : rem_sh[DIM_W-1:0];
    num_nxt = {num_r[NUM_W-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      col_r <= in_column;
      row_r <= in_row;
      src_r <= in_source_pixel;
      eof_r <= in_end_of_frame;
      rem_r <= '0;
      if (cfg.pattern == PAT_GRAD) begin
        num_r <= col_x255;
        den_r <= den_w;
      end else begin
        num_r <= {5'd0, in_column, 3'd0};
        den_r <= wc;
      end
    end else if (cmd.load_b) begin
      red_r <= sat8(num_nxt);
      num_r <= row_x255;
      den_r <= den_h;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  // pattern select
  always_comb begin
    unique case (cfg.pattern)
      PAT_BARS: begin
        if (num_r[0])      px_nxt = 32'h00FF_FFFF;
        else if (num_r[1]) px_nxt = 32'h0000_FF00;
        else if (num_r[2]) px_nxt = 32'h00FF_0000;
        else               px_nxt = 32'h0000_00FF;
      end
      PAT_CHECK: px_nxt = (col_r[5] ^ row_r[5]) ? 32'h00F0_F0F0 : 32'h0020_2020;
      PAT_GRAD:  px_nxt = {8'd0, red_r, sat8(num_r), 8'h40};
      default:   px_nxt = src_r;
    endcase
  end

  assign open_add = open_r + 64'd4;

  // CRC, frame state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r    <= CRC_INIT;
      sig_r    <= '0;
      frames_r <= '0;
      bytes_r  <= '0;
      open_r   <= '0;
    end else begin
      if (cmd.accept && in_start_of_frame) begin
        crc_r  <= CRC_INIT;
        open_r <= '0;
      end
      if (cmd.crc_step) begin
        crc_r <= crc_byte(crc_r, sh_r[7:0]);
      end
      if (cmd.commit) begin
        if (eof_r) begin
          sig_r    <= ~crc_r;
          frames_r <= frames_r + 32'd1;
          bytes_r  <= bytes_r + open_add;
          crc_r    <= CRC_INIT;
          open_r   <= '0;
        end else begin
          open_r <= open_add;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pix) begin
      px_r <= px_nxt;
      sh_r <= px_nxt;
    end else if (cmd.crc_step) begin
      sh_r <= sh_r >> 8;
    end
  end

  // output item register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_pixel           <= px_r;
      out_frame_done      <= eof_r;
      out_frame_signature <= eof_r ? ~crc_r : sig_r;
      out_frames_sent     <= eof_r ? frames_r + 32'd1 : frames_r;
      out_bytes_sent      <= eof_r ? bytes_r + open_add : bytes_r;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/test_pattern_generator_frame_crc.sv -----
// Channel  | Handshake               | Payload
// input    | in_valid / in_ready     | in_column, in_row, in_source_pixel,
//          |                         | in_start_of_frame, in_end_of_frame
// result   | out_valid / out_ready   | out_pixel, out_frame_done,
//          |                         | out_frame_signature, out_frames_sent, out_bytes_sent
// config   | APB cfg_psel..cfg_pready| pattern, width, height at 0x0, 0x4, 0x8
//
// One item in flight. The idle state takes the item, the radix-2 divider runs
// once per division (not for pass-through and checkerboard, once for colour bars,
// twice for gradient), one state forms the pixel, the CRC takes its four bytes
// one at a time and a last state moves the result into the output register.
// A finished item waits in the output register; a new item is taken while it waits.
// Synchronous active-low reset; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module test_pattern_generator_frame_crc
  import tpgfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [11:0] in_column,
  input  wire logic [11:0] in_row,
  input  wire logic [31:0] in_source_pixel,
  input  wire logic        in_start_of_frame,
  input  wire logic        in_end_of_frame,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_pixel,
  output logic             out_frame_done,
  output logic [31:0]      out_frame_signature,
  output logic [31:0]      out_frames_sent,
  output logic [63:0]      out_bytes_sent,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t      cfg;
  ctrl_cmd_t cmd;

  tpgfc_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  tpgfc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .pattern(cfg.pattern), .cmd
  );

  tpgfc_dp u_dp (
    .clk, .rst_n, .cfg, .cmd, .in_column, .in_row, .in_source_pixel,
    .in_start_of_frame, .in_end_of_frame, .out_pixel, .out_frame_done,
    .out_frame_signature, .out_frames_sent, .out_bytes_sent
  );

endmodule
`default_nettype wire

// ----- hdl/tpgfc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tpgfc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pixel,
  input wire logic [63:0] out_bytes_sent
);

  // held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel))
    else $error("result item dropped or changed while stalled");

  // byte total always whole pixels
  a_bytes_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes_sent[1:0] == 2'b00)
    else $error("byte total not a multiple of four");

  // one item at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while busy");

  // reset leaves the block empty and ready
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("block not idle after reset");

endmodule

bind test_pattern_generator_frame_crc tpgfc_checker u_tpgfc_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
  .out_pixel, .out_bytes_sent
);
`default_nettype wire

// ----- verif/tb_test_pattern_generator_frame_crc.sv -----
`timescale 1ns / 1ps
module tb_test_pattern_generator_frame_crc;
  import tpgfc_pkg::*;

  typedef struct {
    logic [11:0] column;
    logic [11:0] row;
    logic [31:0] source_pixel;
    logic        sof;
    logic        eof;
  } pixel_item_t;

  typedef struct {
    logic [31:0] pixel;
    logic        done;
    logic [31:0] signature;
    logic [31:0] frames;
    logic [63:0] bytes;
  } link_pixel_t;

  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [11:0] in_column = '0;
  logic [11:0] in_row = '0;
  logic [31:0] in_source_pixel = '0;
  logic        in_start_of_frame = 1'b0;
  logic        in_end_of_frame = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel;
  logic        out_frame_done;
  logic [31:0] out_frame_signature;
  logic [31:0] out_frames_sent;
  logic [63:0] out_bytes_sent;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  test_pattern_generator_frame_crc dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [1:0]  pattern_sel;
  logic [12:0] width_reg;
  logic [12:0] height_reg;
  logic [31:0] crc_acc;
  logic [31:0] signature_q;
  logic [31:0] frame_count;
  logic [63:0] byte_total;
  logic [63:0] open_byte_count;

  pixel_item_t pending_pixels[$];
  link_pixel_t expected_pixels[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          stall_count = 0;
  int          frames_seen = 0;
  int          pixels_seen = 0;

  function automatic logic [12:0] eff_dim(logic [12:0] v);
    if (v == 0) return 13'd1;
    if (v > MAX_DIMENSION) return 13'(MAX_DIMENSION);
    return v;
  endfunction

  function automatic logic [31:0] crc32c_byte(logic [31:0] c, logic [7:0] b);
    c ^= {24'd0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic logic [31:0] grad_level(logic [11:0] pos, logic [12:0] dim);
    logic [31:0] den;
    logic [31:0] v;
    den = (dim > 1) ? dim - 1 : 1;
    v = (32'(pos) * 255) / den;
    return (v > 255) ? 32'd255 : v;
  endfunction

  function automatic logic [31:0] pattern_pixel(pixel_item_t it);
    logic [12:0] w;
    logic [12:0] h;
    logic [31:0] idx;
    w = eff_dim(width_reg);
    h = eff_dim(height_reg);
    case (pattern_sel)
      PAT_BARS: begin
        idx = (32'(it.column) * 8) / w;
        if (idx[0]) return 32'h00ff_ffff;
        if (idx[1]) return 32'h0000_ff00;
        if (idx[2]) return 32'h00ff_0000;
        return 32'h0000_00ff;
      end
      PAT_CHECK: return ((it.column[5] ^ it.row[5]) != 0) ? 32'h00f0_f0f0 : 32'h0020_2020;
      PAT_GRAD: return (grad_level(it.column, w) << 16) | (grad_level(it.row, h) << 8) | 32'h40;
      default: return it.source_pixel;
    endcase
  endfunction

  // work out the link pixel and counters for one accepted item
  function automatic void predict_link_pixel(pixel_item_t it);
    link_pixel_t r;
    if (it.sof) begin
      crc_acc = CRC_INIT;
      open_byte_count = 0;
    end
    r.pixel = pattern_pixel(it);
    for (int i = 0; i < 4; i++) crc_acc = crc32c_byte(crc_acc, r.pixel[8*i +: 8]);
    open_byte_count += 4;
    if (it.eof) begin
      signature_q = ~crc_acc;
      frame_count += 1;
      byte_total += open_byte_count;
      crc_acc = CRC_INIT;
      open_byte_count = 0;
    end
    r.done = it.eof;
    r.signature = signature_q;
    r.frames = frame_count;
    r.bytes = byte_total;
    expected_pixels.push_back(r);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) predict_link_pixel('{in_column, in_row, in_source_pixel,
                                         in_start_of_frame, in_end_of_frame});
      if (pending_pixels.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pixel_item_t it;
        it = pending_pixels.pop_front();
        in_valid <= 1'b1;
        in_column <= it.column;
        in_row <= it.row;
        in_source_pixel <= it.source_pixel;
        in_start_of_frame <= it.sof;
        in_end_of_frame <= it.eof;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      link_pixel_t e;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch("unexpected item", out_pixel, 0);
      end else begin
        e = expected_pixels.pop_front();
        if (out_pixel !== e.pixel) report_mismatch("out_pixel", out_pixel, e.pixel);
        if (out_frame_done !== e.done) report_mismatch("frame_done", out_frame_done, e.done);
        if (out_frame_done === 1'b1) frames_seen++;
        if (out_frame_signature !== e.signature)
          report_mismatch("frame_signature", out_frame_signature, e.signature);
        if (out_frames_sent !== e.frames)
          report_mismatch("frames_sent", out_frames_sent, e.frames);
        if (out_bytes_sent !== e.bytes) report_mismatch("bytes_sent", out_bytes_sent, e.bytes);
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: cycles without any accepted item
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n || cfg_psel)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_PATTERN:   pattern_sel = val[1:0];
      REG_ACT_WIDTH: width_reg = val[12:0];
      default:       height_reg = val[12:0];
    endcase
  endtask

  // wait until every queued item has gone through and the block is quiet
  task automatic drain;
    while (pending_pixels.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic add_pixel(int col, int row, logic [31:0] src, bit sof, bit eof);
    pixel_item_t it;
    it.column = 12'(col);
    it.row = 12'(row);
    it.source_pixel = src;
    it.sof = sof;
    it.eof = eof;
    pending_pixels.push_back(it);
  endtask

  // mostly well-formed frames, some with missing or stray marks
  task automatic add_frames(int n_pixels, int dim_hi);
    int len;
    int k;
    k = 0;
    while (k < n_pixels) begin
      len = $urandom_range(1, 24);
      for (int i = 0; i < len && k < n_pixels; i++, k++) begin
        bit sof;
        bit eof;
        sof = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(40) == 0);
        eof = (i == len - 1) ? ($urandom_range(9) != 0) : ($urandom_range(40) == 0);
        if ($urandom_range(7) == 0)
          add_pixel($urandom_range(4095), $urandom_range(4095), $urandom, sof, eof);
        else
          add_pixel($urandom_range(dim_hi), $urandom_range(dim_hi), $urandom, sof, eof);
      end
    end
  endtask

  int widths[6] = '{1, 4096, 0, 8191, 800, 37};
  int heights[6] = '{1, 4096, 8191, 0, 600, 13};

  initial begin
    pattern_sel = PAT_PASS;
    width_reg = 800;
    height_reg = 600;
    crc_acc = CRC_INIT;
    signature_q = 0;
    frame_count = 0;
    byte_total = 0;
    open_byte_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, each pattern, single-pixel frame, frame without start
    send_idle_pct = 12;
    recv_idle_pct = 72;
    add_pixel(0, 0, 32'h0000_0000, 1, 0);
    add_pixel(4095, 4095, 32'hffff_ffff, 0, 1);
    add_pixel(5, 7, 32'ha5a5_5a5a, 1, 1);
    add_pixel(12, 3, 32'h5a5a_a5a5, 0, 0);
    add_pixel(31, 32, 32'h1234_5678, 0, 1);
    drain();
    for (int p = 1; p < 4; p++) begin
      write_reg(REG_PATTERN, p);
      add_pixel(0, 0, 0, 1, 0);
      add_pixel(799, 599, 0, 0, 0);
      add_pixel(4095, 4095, 0, 0, 0);
      add_pixel(32, 31, 0, 0, 0);
      add_pixel(100, 300, 0, 0, 1);
      drain();
    end

    // random: walk through the dimension settings and patterns
    for (int ph = 0; ph < 12; ph++) begin
      if (ph == 4) begin
        send_idle_pct = 72;
        recv_idle_pct = 12;
      end else if (ph == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(REG_PATTERN, ph % 4);
      write_reg(REG_ACT_WIDTH, widths[ph % 6]);
      write_reg(REG_ACT_HEIGHT, heights[ph % 6]);
      add_frames(75, (widths[ph % 6] > 1) ? 4095 : 40);
      drain();
    end

    $display("Covered %0d link pixels and %0d frames across all four patterns,",
             pixels_seen, frames_seen);
    $display("width and height extremes, stray frame marks and three stall profiles.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
